// ===== hdl/mie_pkg.sv =====
// Shared types and constants for the mid-range instruction execute unit.
package mie_pkg;

    localparam int STACK_DEPTH_DEF = 8;
    localparam int PC_BITS_DEF     = 13;
    localparam int QUEUE_DEPTH     = 2;

    typedef enum logic [3:0] {
        K_NOP,
        K_CLRWDT,
        K_RETURN,
        K_CLRW,
        K_FNOP,
        K_BYTE,
        K_BIT,
        K_GOTO,
        K_CALL,
        K_LIT
    } kind_t;

    // byte-oriented opcodes (instruction bits 11..8)
    localparam logic [3:0] OP_MOVWF  = 4'd0;
    localparam logic [3:0] OP_CLRF   = 4'd1;
    localparam logic [3:0] OP_SUBWF  = 4'd2;
    localparam logic [3:0] OP_DECF   = 4'd3;
    localparam logic [3:0] OP_IORWF  = 4'd4;
    localparam logic [3:0] OP_ANDWF  = 4'd5;
    localparam logic [3:0] OP_XORWF  = 4'd6;
    localparam logic [3:0] OP_ADDWF  = 4'd7;
    localparam logic [3:0] OP_MOVF   = 4'd8;
    localparam logic [3:0] OP_COMF   = 4'd9;
    localparam logic [3:0] OP_INCF   = 4'd10;
    localparam logic [3:0] OP_DECFSZ = 4'd11;
    localparam logic [3:0] OP_RRF    = 4'd12;
    localparam logic [3:0] OP_RLF    = 4'd13;
    localparam logic [3:0] OP_SWAPF  = 4'd14;
    localparam logic [3:0] OP_INCFSZ = 4'd15;

    // bit-oriented opcodes
    localparam logic [1:0] BOP_BCF   = 2'd0;
    localparam logic [1:0] BOP_BSF   = 2'd1;
    localparam logic [1:0] BOP_BTFSC = 2'd2;
    localparam logic [1:0] BOP_BTFSS = 2'd3;

    // control encodings
    localparam logic [13:0] INS_RETURN = 14'h0008;
    localparam logic [13:0] INS_RETFIE = 14'h0009;
    localparam logic [13:0] INS_CLRWDT = 14'h0064;

    typedef struct packed {
        kind_t       kind;
        logic [3:0]  op;
        logic        d;
        logic [6:0]  f;
        logic [7:0]  k;
        logic [1:0]  bop;
        logic [2:0]  bsel;
        logic [10:0] target;
        logic [7:0]  fv;
        logic        gie;
        logic        load_w;
    } dec_t;

    typedef struct packed {
        logic        file_write;
        logic [6:0]  file_address;
        logic [7:0]  file_data;
        logic [7:0]  w_value;
        logic [2:0]  status_flags;
        logic [12:0] next_pc;
        logic [1:0]  cycles_taken;
        logic        clear_watchdog;
        logic        set_gie;
    } res_t;

endpackage

// ===== hdl/mie_front.sv =====
// Front end: classifies an instruction beat into a decoded record.
module mie_front (
    input  logic [13:0]   instruction,
    input  logic [7:0]    file_value,
    input  logic          file_unimplemented,
    output mie_pkg::dec_t dec
);
    import mie_pkg::*;

    logic [3:0] op;

    assign op = instruction[11:8];

    always_comb
    begin
        dec        = '0;
        dec.kind   = K_NOP;
        dec.op     = op;
        dec.d      = instruction[7];
        dec.f      = instruction[6:0];
        dec.k      = instruction[7:0];
        dec.bop    = instruction[11:10];
        dec.bsel   = instruction[9:7];
        dec.target = instruction[10:0];
        dec.fv     = file_value;
        unique case (instruction[13:12])
            2'd0:
            begin
                if (op == 4'd0 && !instruction[7])
                begin
                    if (instruction == INS_RETURN)
                        dec.kind = K_RETURN;
                    else if (instruction == INS_RETFIE)
                    begin
                        dec.kind = K_RETURN;
                        dec.gie  = 1'b1;
                    end
                    else if (instruction == INS_CLRWDT)
                        dec.kind = K_CLRWDT;
                end
                else if (op == 4'd1 && !instruction[7])
                    dec.kind = K_CLRW;
                else
                    dec.kind = file_unimplemented ? K_FNOP : K_BYTE;
            end
            2'd1:
                dec.kind = file_unimplemented ? K_FNOP : K_BIT;
            2'd2:
                dec.kind = instruction[11] ? K_GOTO : K_CALL;
            default:
            begin
                if (op >= 4'd4 && op <= 4'd7)
                begin
                    dec.kind   = K_RETURN;
                    dec.load_w = 1'b1;
                end
                else if (op == 4'd11)
                    dec.kind = K_NOP;
                else
                    dec.kind = K_LIT;
            end
        endcase
    end

endmodule

// ===== hdl/mie_queue.sv =====
// Short queue of decoded instructions between front and back end.
module mie_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  mie_pkg::dec_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output logic          rd_valid,
    output mie_pkg::dec_t rd_data
);
    import mie_pkg::*;

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    dec_t             slot_reg [QUEUE_DEPTH];
    logic [QW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [QW:0]      count_reg, count_next;
    logic             do_wr, do_rd;

    assign full     = (count_reg == (QW+1)'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (!do_wr && do_rd)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == QW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == QW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== hdl/mie_back.sv =====
// Back end: executes decoded instructions against W, flags, PC and return stack.
module mie_back #(
    parameter int STACK_DEPTH = mie_pkg::STACK_DEPTH_DEF,
    parameter int PC_BITS     = mie_pkg::PC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  mie_pkg::dec_t in_dec,
    output logic          in_take,
    output logic          out_valid,
    output mie_pkg::res_t out_res,
    input  logic          out_take
);
    import mie_pkg::*;

    localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int FW = $clog2(STACK_DEPTH + 1);

    logic [7:0]          w_reg, w_next;
    logic                c_reg, c_next, dc_reg, dc_next, z_reg, z_next;
    logic [PC_BITS-1:0]  pc_reg, pc_next, pc1, pc2, stk_rd, tgt;
    logic [12:0]         tgt13;
    logic [PC_BITS-1:0]  stack_mem [STACK_DEPTH];
    logic [SW-1:0]       top_reg, top_next, top_m1, top_p1;
    logic [FW-1:0]       fill_reg, fill_next;
    logic                push;
    logic                out_valid_reg;
    res_t                res_reg, res_next;
    logic                fire;

    assign fire      = in_valid && (!out_valid_reg || out_take);
    assign in_take   = fire;
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    assign pc1    = pc_reg + 1'b1;
    assign pc2    = pc_reg + PC_BITS'(2);
    assign tgt13  = {13'(pc_reg) & 13'h1800} | {2'b00, in_dec.target};
    assign tgt    = tgt13[PC_BITS-1:0];
    assign top_m1 = (top_reg == '0) ? SW'(STACK_DEPTH-1) : top_reg - 1'b1;
    assign top_p1 = (top_reg == SW'(STACK_DEPTH-1)) ? '0 : top_reg + 1'b1;
    assign stk_rd = stack_mem[top_m1];

    always_comb
    begin
        logic [7:0] r, a, b, m;
        logic [8:0] sum9;
        logic       setz, skip, sub_op, add_op;
        r = '0; a = '0; b = '0; m = '0; sum9 = '0;
        setz = 1'b0; skip = 1'b0; sub_op = 1'b0; add_op = 1'b0;
        w_next    = w_reg;
        c_next    = c_reg;
        dc_next   = dc_reg;
        z_next    = z_reg;
        pc_next   = pc1;
        top_next  = top_reg;
        fill_next = fill_reg;
        push      = 1'b0;
        res_next  = '0;
        res_next.cycles_taken = 2'd1;

        unique case (in_dec.kind)
            K_NOP, K_FNOP:
                res_next.file_address = (in_dec.kind == K_FNOP) ? in_dec.f : 7'd0;
            K_CLRWDT:
                res_next.clear_watchdog = 1'b1;
            K_CLRW:
            begin
                w_next = '0;
                z_next = 1'b1;
            end
            K_RETURN:
            begin
                res_next.cycles_taken = 2'd2;
                res_next.set_gie      = in_dec.gie;
                if (in_dec.load_w)
                    w_next = in_dec.k;
                if (fill_reg != '0)
                begin
                    pc_next   = stk_rd;
                    top_next  = top_m1;
                    fill_next = fill_reg - 1'b1;
                end
            end
            K_GOTO, K_CALL:
            begin
                res_next.cycles_taken = 2'd2;
                pc_next = tgt;
                if (in_dec.kind == K_CALL)
                begin
                    push     = 1'b1;
                    top_next = top_p1;
                    if (fill_reg < FW'(STACK_DEPTH))
                        fill_next = fill_reg + 1'b1;
                end
            end
            K_BYTE:
            begin
                res_next.file_address = in_dec.f;
                setz = 1'b1;
                a = in_dec.fv;
                b = w_reg;
                unique case (in_dec.op)
                    OP_MOVWF:  begin r = w_reg; setz = 1'b0; end
                    OP_CLRF:   r = '0;
                    OP_SUBWF:  sub_op = 1'b1;
                    OP_DECF:   r = in_dec.fv - 1'b1;
                    OP_IORWF:  r = in_dec.fv | w_reg;
                    OP_ANDWF:  r = in_dec.fv & w_reg;
                    OP_XORWF:  r = in_dec.fv ^ w_reg;
                    OP_ADDWF:  add_op = 1'b1;
                    OP_MOVF:   r = in_dec.fv;
                    OP_COMF:   r = ~in_dec.fv;
                    OP_INCF:   r = in_dec.fv + 1'b1;
                    OP_DECFSZ:
                    begin
                        r = in_dec.fv - 1'b1; setz = 1'b0; skip = (r == '0);
                    end
                    OP_RRF:
                    begin
                        r = {c_reg, in_dec.fv[7:1]}; c_next = in_dec.fv[0]; setz = 1'b0;
                    end
                    OP_RLF:
                    begin
                        r = {in_dec.fv[6:0], c_reg}; c_next = in_dec.fv[7]; setz = 1'b0;
                    end
                    OP_SWAPF:  begin r = {in_dec.fv[3:0], in_dec.fv[7:4]}; setz = 1'b0; end
                    OP_INCFSZ:
                    begin
                        r = in_dec.fv + 1'b1; setz = 1'b0; skip = (r == '0);
                    end
                endcase
            end
            K_BIT:
            begin
                res_next.file_address = in_dec.f;
                m = 8'd1 << in_dec.bsel;
                unique case (in_dec.bop)
                    BOP_BCF:
                    begin
                        res_next.file_write = 1'b1; res_next.file_data = in_dec.fv & ~m;
                    end
                    BOP_BSF:
                    begin
                        res_next.file_write = 1'b1; res_next.file_data = in_dec.fv | m;
                    end
                    BOP_BTFSC: skip = ((in_dec.fv & m) == '0);
                    BOP_BTFSS: skip = ((in_dec.fv & m) != '0);
                endcase
            end
            K_LIT:
            begin
                setz = 1'b1;
                if (in_dec.op <= 4'd3)
                begin
                    r = in_dec.k; setz = 1'b0;
                end
                else if (in_dec.op == 4'd8)
                    r = w_reg | in_dec.k;
                else if (in_dec.op == 4'd9)
                    r = w_reg & in_dec.k;
                else if (in_dec.op == 4'd10)
                    r = w_reg ^ in_dec.k;
                else if (in_dec.op <= 4'd13)
                begin
                    sub_op = 1'b1; a = in_dec.k; b = w_reg;
                end
                else
                begin
                    add_op = 1'b1; a = w_reg; b = in_dec.k;
                end
            end
            default: ;
        endcase

        // shared 8-bit adder / subtractor; C and DC mean "no borrow" on subtract
        if (add_op)
        begin
            sum9    = {1'b0, a} + {1'b0, b};
            r       = sum9[7:0];
            c_next  = sum9[8];
            dc_next = ({1'b0, a[3:0]} + {1'b0, b[3:0]}) > 5'h0F;
        end
        else if (sub_op)
        begin
            r       = a - b;
            c_next  = (a >= b);
            dc_next = (a[3:0] >= b[3:0]);
        end

        if (setz)
            z_next = (r == '0);

        if (in_dec.kind == K_LIT)
            w_next = r;
        else if (in_dec.kind == K_BYTE)
        begin
            if (in_dec.d)
            begin
                res_next.file_write = 1'b1;
                res_next.file_data  = r;
            end
            else
                w_next = r;
        end

        if (skip)
        begin
            pc_next = pc2;
            res_next.cycles_taken = 2'd2;
        end

        res_next.w_value      = w_next;
        res_next.status_flags = {z_next, dc_next, c_next};
        res_next.next_pc      = 13'(pc_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg         <= '0;
            c_reg         <= 1'b0;
            dc_reg        <= 1'b0;
            z_reg         <= 1'b0;
            pc_reg        <= '0;
            top_reg       <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                w_reg    <= w_next;
                c_reg    <= c_next;
                dc_reg   <= dc_next;
                z_reg    <= z_next;
                pc_reg   <= pc_next;
                top_reg  <= top_next;
                fill_reg <= fill_next;
            end
            if (fire)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            res_reg <= res_next;
        if (fire && push)
            stack_mem[top_reg] <= pc1;
    end

endmodule

// ===== hdl/midrange_mcu_instruction_execute_unit.sv =====
// Top level of the mid-range instruction execute unit.
// A pushed beat is written into the decode queue, then executed into the result register.
// Throughput: one instruction per cycle while no unpopped result holds the back end.
// A two-entry decode queue and a one-entry result register decouple the two sides.
// Reset (rst_n low, asynchronous) clears W, flags, PC, stack pointer and fill, and empties the queue and result.
// Return stack contents are not reset; an entry is only read after a call wrote it.
module midrange_mcu_instruction_execute_unit #(
    parameter int STACK_DEPTH = mie_pkg::STACK_DEPTH_DEF,
    parameter int PC_BITS     = mie_pkg::PC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [13:0] instruction,
    input  logic [7:0]  file_value,
    input  logic        file_unimplemented,
    output logic        empty,
    input  logic        pop,
    output logic        file_write,
    output logic [6:0]  file_address,
    output logic [7:0]  file_data,
    output logic [7:0]  w_value,
    output logic [2:0]  status_flags,
    output logic [12:0] next_pc,
    output logic [1:0]  cycles_taken,
    output logic        clear_watchdog,
    output logic        set_gie
);
    import mie_pkg::*;

    dec_t front_dec, q_dec;
    res_t res;
    logic q_valid, q_take, out_valid;

    mie_front u_front (
        .instruction        (instruction),
        .file_value         (file_value),
        .file_unimplemented (file_unimplemented),
        .dec                (front_dec)
    );

    mie_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_data  (front_dec),
        .full     (full),
        .rd_en    (q_take),
        .rd_valid (q_valid),
        .rd_data  (q_dec)
    );

    mie_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .PC_BITS     (PC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_dec    (q_dec),
        .in_take   (q_take),
        .out_valid (out_valid),
        .out_res   (res),
        .out_take  (pop)
    );

    assign empty          = !out_valid;
    assign file_write     = res.file_write;
    assign file_address   = res.file_address;
    assign file_data      = res.file_data;
    assign w_value        = res.w_value;
    assign status_flags   = res.status_flags;
    assign next_pc        = res.next_pc;
    assign cycles_taken   = res.cycles_taken;
    assign clear_watchdog = res.clear_watchdog;
    assign set_gie        = res.set_gie;

    a_cycles_legal: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (cycles_taken == 2'd1 || cycles_taken == 2'd2))
        else $error("cycles_taken out of range");

    a_no_data_without_write: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !file_write) |-> (file_data == 8'd0))
        else $error("file_data set without file_write");

    a_gie_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && set_gie) |-> (cycles_taken == 2'd2 && !file_write))
        else $error("retfie result malformed");

    a_wdt_plain: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && clear_watchdog) |-> (!file_write && cycles_taken == 2'd1 && !set_gie))
        else $error("clrwdt result malformed");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(next_pc) && $stable(w_value)))
        else $error("stalled result changed");

endmodule

// ===== tb/sv/midrange_mcu_instruction_execute_unit_tb.sv =====
// Self-checking testbench for the mid-range instruction execute unit.
module midrange_mcu_instruction_execute_unit_tb;
    import mie_pkg::*;

    localparam int STACK_DEPTH = 8;
    localparam int RAND_ITEMS  = 1650;

    class exec_scoreboard;
        res_t        expected_q[$];
        int          mismatches;
        logic [7:0]  w;
        logic        c, dc, z;
        logic [12:0] pc;
        logic [12:0] ret_stack[STACK_DEPTH];
        int          top, fill;

        function void clear();
            expected_q.delete();
            mismatches = 0;
            w = 0; c = 0; dc = 0; z = 0; pc = 0; top = 0; fill = 0;
            foreach (ret_stack[i]) ret_stack[i] = 0;
        endfunction

        function logic [12:0] pop_ret(logic [12:0] fallback);
            if (fill == 0) return fallback;
            top = (top + STACK_DEPTH - 1) % STACK_DEPTH;
            fill--;
            return ret_stack[top];
        endfunction

        function logic [7:0] add8(logic [7:0] a, logic [7:0] b);
            logic [8:0] s;
            s = {1'b0, a} + {1'b0, b};
            c = s[8];
            dc = ({1'b0, a[3:0]} + {1'b0, b[3:0]}) > 5'd15;
            return s[7:0];
        endfunction

        function logic [7:0] sub8(logic [7:0] a, logic [7:0] b);
            c = a >= b;
            dc = a[3:0] >= b[3:0];
            return a - b;
        endfunction

        // execute one instruction and queue its result
        function void note_instruction(logic [13:0] ins, logic [7:0] fv, logic unimp);
            res_t        r;
            logic [3:0]  op;
            logic        d, setz, skip;
            logic [7:0]  v, k, m;
            logic [12:0] pc1;
            op = ins[11:8];
            d = ins[7];
            k = ins[7:0];
            pc1 = pc + 13'd1;
            r = '0;
            r.next_pc = pc1;
            r.cycles_taken = 2'd1;
            skip = 0;
            case (ins[13:12])
                2'd0:
                begin
                    if (op == OP_MOVWF && !d)
                    begin
                        if (ins == INS_RETURN || ins == INS_RETFIE)
                        begin
                            r.next_pc = pop_ret(pc1);
                            r.cycles_taken = 2'd2;
                            r.set_gie = (ins == INS_RETFIE);
                        end
                        else if (ins == INS_CLRWDT)
                            r.clear_watchdog = 1;
                    end
                    else if (op == OP_CLRF && !d)
                    begin
                        w = 0;
                        z = 1;
                    end
                    else
                    begin
                        r.file_address = ins[6:0];
                        if (!unimp)
                        begin
                            setz = 1;
                            case (op)
                                OP_MOVWF:  begin v = w; setz = 0; end
                                OP_CLRF:   v = 0;
                                OP_SUBWF:  v = sub8(fv, w);
                                OP_DECF:   v = fv - 8'd1;
                                OP_IORWF:  v = fv | w;
                                OP_ANDWF:  v = fv & w;
                                OP_XORWF:  v = fv ^ w;
                                OP_ADDWF:  v = add8(fv, w);
                                OP_MOVF:   v = fv;
                                OP_COMF:   v = ~fv;
                                OP_INCF:   v = fv + 8'd1;
                                OP_DECFSZ: begin v = fv - 8'd1; setz = 0; skip = (v == 0); end
                                OP_RRF:    begin v = {c, fv[7:1]}; c = fv[0]; setz = 0; end
                                OP_RLF:    begin v = {fv[6:0], c}; c = fv[7]; setz = 0; end
                                OP_SWAPF:  begin v = {fv[3:0], fv[7:4]}; setz = 0; end
                                default:   begin v = fv + 8'd1; setz = 0; skip = (v == 0); end
                            endcase
                            if (setz) z = (v == 0);
                            if (d)
                            begin
                                r.file_write = 1;
                                r.file_data = v;
                            end
                            else
                                w = v;
                        end
                    end
                end
                2'd1:
                begin
                    m = 8'd1 << ins[9:7];
                    r.file_address = ins[6:0];
                    if (!unimp)
                    begin
                        case (ins[11:10])
                            BOP_BCF:   begin r.file_write = 1; r.file_data = fv & ~m; end
                            BOP_BSF:   begin r.file_write = 1; r.file_data = fv | m; end
                            BOP_BTFSC: skip = (fv & m) == 0;
                            default:   skip = (fv & m) != 0;
                        endcase
                    end
                end
                2'd2:
                begin
                    if (!ins[11])
                    begin
                        ret_stack[top] = pc1;
                        top = (top + 1) % STACK_DEPTH;
                        if (fill < STACK_DEPTH) fill++;
                    end
                    r.next_pc = {pc[12:11], ins[10:0]};
                    r.cycles_taken = 2'd2;
                end
                default:
                begin
                    if (op <= 4'd3)
                        w = k;
                    else if (op <= 4'd7)
                    begin
                        w = k;
                        r.next_pc = pop_ret(pc1);
                        r.cycles_taken = 2'd2;
                    end
                    else if (op == 4'd8) begin w = w | k; z = (w == 0); end
                    else if (op == 4'd9) begin w = w & k; z = (w == 0); end
                    else if (op == 4'd10) begin w = w ^ k; z = (w == 0); end
                    else if (op == 4'd11) begin end
                    else if (op <= 4'd13) begin w = sub8(k, w); z = (w == 0); end
                    else begin w = add8(w, k); z = (w == 0); end
                end
            endcase
            if (skip)
            begin
                r.next_pc = pc + 13'd2;
                r.cycles_taken = 2'd2;
            end
            pc = r.next_pc;
            r.w_value = w;
            r.status_flags = {z, dc, c};
            expected_q.push_back(r);
        endfunction

        function void check_result(res_t got);
            res_t exp_r;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            exp_r = expected_q.pop_front();
            if (got !== exp_r)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p, got %p", exp_r, got);
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        push = 0;
    logic        full;
    logic [13:0] instruction = 0;
    logic [7:0]  file_value = 0;
    logic        file_unimplemented = 0;
    logic        empty;
    logic        pop = 0;
    res_t        got;
    exec_scoreboard sb;
    bit          stim_done = 0;
    int          calls_outstanding = 0;

    midrange_mcu_instruction_execute_unit u_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .instruction(instruction), .file_value(file_value),
        .file_unimplemented(file_unimplemented), .empty(empty), .pop(pop),
        .file_write(got.file_write), .file_address(got.file_address),
        .file_data(got.file_data), .w_value(got.w_value),
        .status_flags(got.status_flags), .next_pc(got.next_pc),
        .cycles_taken(got.cycles_taken), .clear_watchdog(got.clear_watchdog),
        .set_gie(got.set_gie)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    function int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // one instruction beat; push stays high across back-to-back beats
    task send_instruction(logic [13:0] ins, logic [7:0] fv, logic unimp);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            push <= 0;
            repeat (g) @(posedge clk);
        end
        push <= 1;
        instruction <= ins;
        file_value <= fv;
        file_unimplemented <= unimp;
        @(posedge clk);
        while (full) @(posedge clk);
        sb.note_instruction(ins, fv, unimp);
    endtask

    // mostly well-formed code: byte ops, bit ops, literals, gotos, calls and returns
    function logic [13:0] random_instruction();
        int p;
        p = $urandom_range(0, 99);
        if (p < 35) return {2'b00, 12'($urandom)};
        if (p < 55) return {2'b01, 12'($urandom)};
        if (p < 70) return {2'b11, 12'($urandom)};
        if (p < 80) return {2'b10, 12'($urandom)};
        if (p < 86) return INS_RETURN;
        if (p < 89) return INS_RETFIE;
        if (p < 91) return INS_CLRWDT;
        return 14'($urandom);
    endfunction

    function logic [7:0] random_byte();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0) return 8'h00;
        if (p == 1) return 8'hFF;
        if (p == 2) return 8'h01;
        return 8'($urandom);
    endfunction

    initial
    begin
        sb = new();
        sb.clear();
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: literals, arithmetic extremes, rotates, skips, stack
        send_instruction(14'h3000, 8'h00, 0);          // movlw 0
        send_instruction(14'h3E01, 8'h00, 0);          // addlw 1
        send_instruction(14'h3CFF, 8'h00, 0);          // sublw ff
        send_instruction(14'h3C00, 8'h00, 0);          // sublw 0 (borrow)
        send_instruction(14'h3E0F, 8'h00, 0);          // addlw 0f
        send_instruction(14'h0008, 8'h00, 0);          // return, empty stack
        send_instruction(14'h0009, 8'h00, 0);          // retfie, empty stack
        send_instruction(14'h3412, 8'h00, 0);          // retlw, empty stack
        send_instruction(14'h0064, 8'h00, 0);          // clrwdt
        send_instruction(14'h0100, 8'h00, 0);          // clrw
        send_instruction(14'h0CFF, 8'h01, 0);          // rrf
        send_instruction(14'h0DFF, 8'h80, 0);          // rlf
        send_instruction(14'h0B80, 8'h01, 0);          // decfsz skip
        send_instruction(14'h0F80, 8'hFF, 0);          // incfsz skip
        send_instruction(14'h0783, 8'hFF, 1);          // unimplemented addwf
        send_instruction(14'h0083, 8'h55, 0);          // movwf status
        send_instruction(14'h1BFF, 8'h80, 0);          // btfsc
        send_instruction(14'h1FFF, 8'h80, 0);          // btfss
        send_instruction(14'h2FFF, 8'h00, 0);          // goto 7ff
        for (int i = 0; i < 10; i++)                   // overflow the stack
            send_instruction(14'h2000 | 14'(i), 8'h00, 0);
        for (int i = 0; i < 10; i++)                   // unwind past empty
            send_instruction(INS_RETURN, 8'h00, 0);
        push <= 0;
        // hold off until all results are out
        while (sb.expected_q.size() != 0) @(posedge clk);
        for (int i = 0; i < RAND_ITEMS; i++)
            send_instruction(random_instruction(), random_byte(), ($urandom_range(0, 7) == 0));
        push <= 0;
        stim_done = 1;
    end

    initial
    begin
        int g;
        @(posedge rst_n);
        forever
        begin
            g = gap_len();
            if (g > 0)
            begin
                pop <= 0;
                repeat (g) @(posedge clk);
            end
            pop <= 1;
            @(posedge clk);
            while (empty) @(posedge clk);
            sb.check_result(got);
        end
    end

    initial
    begin
        wait (stim_done);
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #10000000;
        $display("== FAIL ==");
        $finish;
    end
endmodule
